// ----- design/shr_pkg.sv -----
// shared constants, command codes and remainder-unit structs for the history ring
`default_nettype none

package shr_pkg;

  // ring geometry
  localparam int DEPTH     = 64;
  localparam int ELEM_BITS = 32;
  localparam int SLOT_W    = $clog2(DEPTH);
  localparam int LEN_W     = $clog2(DEPTH + 1);

  // word field widths
  localparam int CMD_W  = 3;
  localparam int WORD_W = 32;
  localparam int SEQ_W  = 32;
  localparam int AMT_W  = 7;

  // remainder unit operand widths and step counter
  localparam int MOD_W    = SEQ_W + 1;
  localparam int NARROW_W = LEN_W + 1;
  localparam int CNT_W    = $clog2(MOD_W + 1);

  // status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // command codes
  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND  = 3'd0,
    CMD_READ    = 3'd1,
    CMD_RECENT  = 3'd2,
    CMD_FORWARD = 3'd3,
    CMD_BACK    = 3'd4
  } cmd_t;

  // request to the remainder unit
  typedef struct packed {
    logic             start;
    logic             wide;
    logic [MOD_W-1:0] value;
  } mod_req_t;

  // answer of the remainder unit
  typedef struct packed {
    logic              busy;
    logic [SLOT_W-1:0] rem;
  } mod_rsp_t;

endpackage

`default_nettype wire

// ----- design/sequenced_history_ring.sv -----
// Sequenced history ring: a ring of up to 64 tagged element words with append, read by
// sequence number, newest-first recall and slot index arithmetic. One word is taken at a
// time; s_axis_tready is high only while the block is idle, and the finished result sits in
// an output register so the next word can be taken while it waits. The stored head and
// tail and the slot results of read, forward and back are reduced modulo the ring length
// by a shared bit-serial remainder unit, which takes both slot-sized operands and the
// wider sequence offset of a read. Every command waits on this unit, and all commands take
// longer when m_axis_tready is held low. Sequence tags reset through one valid flop per
// slot, so no clearing pass follows reset.
`default_nettype none

module sequenced_history_ring (
  input  wire logic                       clk,
  input  wire logic                       rst,
  // ring length register
  input  wire logic                       cfg_wr_en,
  input  wire logic [shr_pkg::LEN_W-1:0]  cfg_wr_data,
  // command words
  input  wire logic                       s_axis_tvalid,
  output logic                            s_axis_tready,
  // element_in[31:0], wanted_seq[63:32], slot_in[69:64], amount[76:70], zero fill
  input  wire logic [79:0]                s_axis_tdata,
  // cmd[2:0]
  input  wire logic [2:0]                 s_axis_tuser,
  // result words
  output logic                            m_axis_tvalid,
  input  wire logic                       m_axis_tready,
  // element_out[31:0], seq_out[63:32], slot_out[69:64], zero fill
  output logic [71:0]                     m_axis_tdata,
  // status[0]
  output logic [0:0]                      m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int SW = shr_pkg::SLOT_W;
  localparam int LW = shr_pkg::LEN_W;
  localparam int MW = shr_pkg::MOD_W;

  typedef enum logic [11:0] {
    S_IDLE     = 12'b0000_0000_0001,
    S_HEAD     = 12'b0000_0000_0010,
    S_TAIL     = 12'b0000_0000_0100,
    S_RD_YOUNG = 12'b0000_0000_1000,
    S_RD_OLD   = 12'b0000_0001_0000,
    S_RD_OLD2  = 12'b0000_0010_0000,
    S_RD_CHK   = 12'b0000_0100_0000,
    S_RD_IDX   = 12'b0000_1000_0000,
    S_RD_ELEM  = 12'b0001_0000_0000,
    S_BACK1    = 12'b0010_0000_0000,
    S_SLOT     = 12'b0100_0000_0000,
    S_REC_DATA = 12'b1000_0000_0000
  } state_t;

  state_t state;

  // configuration and ring state
  logic [LW-1:0]                ring_length;
  logic [LW-1:0]                eff_len;
  logic [SW-1:0]                head_slot;
  logic [SW-1:0]                tail_slot;
  logic [shr_pkg::SEQ_W-1:0]    next_seq;
  logic [shr_pkg::DEPTH-1:0]    seq_valid;

  // latched command word
  logic [shr_pkg::CMD_W-1:0]    cmd_r;
  logic [shr_pkg::ELEM_BITS-1:0] elem_r;
  logic [shr_pkg::SEQ_W-1:0]    want_r;
  logic [SW-1:0]                slot_r;
  logic [shr_pkg::AMT_W-1:0]    amt_r;
  logic [shr_pkg::AMT_W-1:0]    amt_c;

  // working registers
  logic [SW-1:0]                h_r;
  logic [SW-1:0]                t_r;
  logic [SW-1:0]                lv_r;
  logic [SW-1:0]                idx_r;
  logic [shr_pkg::AMT_W-1:0]    cnt_r;
  logic [shr_pkg::SEQ_W-1:0]    young_r;
  logic [shr_pkg::SEQ_W-1:0]    old_r;

  // output register
  logic                         out_valid;
  logic [shr_pkg::WORD_W-1:0]   out_elem;
  logic [shr_pkg::SEQ_W-1:0]    out_seq;
  logic [SW-1:0]                out_slot;
  logic                         out_status;
  logic                         out_last;

  // memories and remainder unit
  logic                         elem_wr_en;
  logic                         elem_rd_en;
  logic [SW-1:0]                elem_rd_addr;
  logic [shr_pkg::ELEM_BITS-1:0] elem_rd_data;
  logic                         seq_wr_en;
  logic                         seq_rd_en;
  logic [SW-1:0]                seq_rd_addr;
  logic [shr_pkg::SEQ_W-1:0]    seq_rd_data;
  logic                         seq_rd_ok;
  logic [shr_pkg::SEQ_W-1:0]    seq_tag;
  shr_pkg::mod_req_t            mod_req;
  shr_pkg::mod_rsp_t            mod_rsp;

  // derived control
  logic                         in_fire;
  logic                         out_free;
  logic                         out_load;
  logic                         cmd_ok;
  logic                         app_fire;
  logic [SW-1:0]                nxt;
  logic [SW-1:0]                tail_now;
  logic [SW-1:0]                tail_after;
  logic [SW-1:0]                t_plus;
  logic [SW-1:0]                nidx;
  logic                         rec_fin;
  logic                         out_range;

  // wrap a slot index one step forward
  function automatic logic [SW-1:0] inc_wrap(input logic [SW-1:0] s,
                                             input logic [LW-1:0] n);
    logic [SW:0] p;
    p = (SW + 1)'(s) + 1'b1;
    inc_wrap = (p == (SW + 1)'(n)) ? '0 : SW'(p);
  endfunction

  // effective ring length, clamped to the legal range
  always_comb begin
    if (ring_length < LW'(2)) begin
      eff_len = LW'(2);
    end else if (ring_length > LW'(shr_pkg::DEPTH)) begin
      eff_len = LW'(shr_pkg::DEPTH);
    end else begin
      eff_len = ring_length;
    end
  end

  // ring length register
  always_ff @(posedge clk) begin
    if (rst) begin
      ring_length <= LW'(shr_pkg::DEPTH);
    end else if (cfg_wr_en) begin
      ring_length <= cfg_wr_data;
    end
  end

  // handshake and small index arithmetic
  always_comb begin
    s_axis_tready = (state == S_IDLE);
    in_fire       = s_axis_tvalid && s_axis_tready;
    out_free      = !out_valid || m_axis_tready;
    cmd_ok        = (s_axis_tuser == shr_pkg::CMD_APPEND) ||
                    (s_axis_tuser == shr_pkg::CMD_READ) ||
                    (s_axis_tuser == shr_pkg::CMD_RECENT) ||
                    (s_axis_tuser == shr_pkg::CMD_FORWARD) ||
                    (s_axis_tuser == shr_pkg::CMD_BACK);
    amt_c         = (amt_r > shr_pkg::AMT_W'(shr_pkg::DEPTH)) ?
                    shr_pkg::AMT_W'(shr_pkg::DEPTH) : amt_r;
    tail_now      = mod_rsp.rem;
    nxt           = inc_wrap(h_r, eff_len);
    tail_after    = (nxt == tail_now) ? inc_wrap(tail_now, eff_len) : tail_now;
    t_plus        = inc_wrap(t_r, eff_len);
    nidx          = (idx_r == '0) ? SW'(eff_len - 1'b1) : idx_r - 1'b1;
    rec_fin       = (cnt_r + 1'b1 == amt_c) || (nidx == t_r);
    seq_tag       = seq_rd_ok ? seq_rd_data : '0;
    out_range     = (want_r < old_r) || (want_r > young_r);
    app_fire      = (state == S_TAIL) && !mod_rsp.busy && out_free &&
                    (cmd_r == shr_pkg::CMD_APPEND);
    // a finished result word enters the output register
    out_load      = out_free &&
                    (((state == S_TAIL) && !mod_rsp.busy &&
                      ((cmd_r == shr_pkg::CMD_APPEND) ||
                       ((cmd_r == shr_pkg::CMD_BACK) && (amt_r == '0)))) ||
                     ((state == S_RD_CHK) && out_range) ||
                     (state == S_RD_ELEM) ||
                     ((state == S_SLOT) && !mod_rsp.busy) ||
                     (state == S_REC_DATA));
  end

  // memory ports and remainder unit requests
  always_comb begin
    mod_req      = '0;
    elem_wr_en   = 1'b0;
    elem_rd_en   = 1'b0;
    elem_rd_addr = idx_r;
    seq_wr_en    = 1'b0;
    seq_rd_en    = 1'b0;
    seq_rd_addr  = h_r;
    case (state)
      S_IDLE: begin
        if (in_fire && cmd_ok) begin
          mod_req.start = 1'b1;
          mod_req.value = MW'(head_slot);
        end
      end
      S_HEAD: begin
        if (!mod_rsp.busy) begin
          mod_req.start = 1'b1;
          mod_req.value = MW'(tail_slot);
        end
      end
      S_TAIL: begin
        if (!mod_rsp.busy) begin
          case (cmd_r)
            shr_pkg::CMD_APPEND: begin
              elem_wr_en = out_free;
              seq_wr_en  = out_free;
            end
            shr_pkg::CMD_READ: begin
              seq_rd_en   = 1'b1;
              seq_rd_addr = h_r;
            end
            shr_pkg::CMD_RECENT: begin
              elem_rd_en   = (amt_c != '0);
              elem_rd_addr = h_r;
            end
            shr_pkg::CMD_FORWARD: begin
              mod_req.start = 1'b1;
              mod_req.value = MW'(slot_r) + MW'(amt_r);
            end
            shr_pkg::CMD_BACK: begin
              mod_req.start = (amt_r != '0);
              mod_req.value = MW'(amt_r);
            end
            default: begin
            end
          endcase
        end
      end
      S_RD_YOUNG: begin
        seq_rd_en   = 1'b1;
        seq_rd_addr = t_r;
      end
      S_RD_OLD: begin
        seq_rd_en   = (seq_tag == '0);
        seq_rd_addr = t_plus;
      end
      S_RD_CHK: begin
        if (!out_range) begin
          mod_req.start = 1'b1;
          mod_req.wide  = 1'b1;
          mod_req.value = MW'(lv_r) + MW'(want_r - old_r);
        end
      end
      S_RD_IDX: begin
        elem_rd_en   = !mod_rsp.busy;
        elem_rd_addr = mod_rsp.rem;
      end
      S_BACK1: begin
        if (!mod_rsp.busy) begin
          mod_req.start = 1'b1;
          mod_req.value = MW'(slot_r) + MW'(eff_len) - MW'(mod_rsp.rem);
        end
      end
      S_REC_DATA: begin
        elem_rd_en   = out_free && !rec_fin;
        elem_rd_addr = nidx;
      end
      default: begin
      end
    endcase
  end

  // sequence tag valid flags, cleared at reset
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_valid <= '0;
    end else if (seq_wr_en) begin
      seq_valid[nxt] <= 1'b1;
    end
  end

  // tag read qualifier follows the read data
  always_ff @(posedge clk) begin
    if (seq_rd_en) begin
      seq_rd_ok <= seq_valid[seq_rd_addr];
    end
  end

  // output word valid: set on a load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer, ring pointers and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head_slot <= '0;
      tail_slot <= '0;
      next_seq  <= shr_pkg::SEQ_W'(1);
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            cmd_r  <= s_axis_tuser;
            elem_r <= s_axis_tdata[shr_pkg::ELEM_BITS-1:0];
            want_r <= s_axis_tdata[63:32];
            slot_r <= s_axis_tdata[69:64];
            amt_r  <= s_axis_tdata[76:70];
            if (cmd_ok) begin
              state <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          if (!mod_rsp.busy) begin
            h_r   <= mod_rsp.rem;
            state <= S_TAIL;
          end
        end
        S_TAIL: begin
          if (!mod_rsp.busy) begin
            t_r <= tail_now;
            case (cmd_r)
              shr_pkg::CMD_APPEND: begin
                if (out_free) begin
                  head_slot  <= nxt;
                  tail_slot  <= tail_after;
                  next_seq   <= next_seq + 1'b1;
                  out_elem   <= '0;
                  out_seq    <= next_seq;
                  out_slot   <= nxt;
                  out_status <= shr_pkg::STATUS_OK;
                  out_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end
              shr_pkg::CMD_READ: begin
                state <= S_RD_YOUNG;
              end
              shr_pkg::CMD_RECENT: begin
                idx_r <= h_r;
                cnt_r <= '0;
                state <= (amt_c == '0) ? S_IDLE : S_REC_DATA;
              end
              shr_pkg::CMD_FORWARD: begin
                state <= S_SLOT;
              end
              shr_pkg::CMD_BACK: begin
                if (amt_r != '0) begin
                  state <= S_BACK1;
                end else if (out_free) begin
                  out_elem   <= '0;
                  out_seq    <= '0;
                  out_slot   <= h_r;
                  out_status <= shr_pkg::STATUS_OK;
                  out_last   <= 1'b1;
                  state      <= S_IDLE;
                end
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD_YOUNG: begin
          young_r <= seq_tag;
          state   <= S_RD_OLD;
        end
        S_RD_OLD: begin
          if (seq_tag == '0) begin
            lv_r  <= t_plus;
            state <= S_RD_OLD2;
          end else begin
            old_r <= seq_tag;
            lv_r  <= t_r;
            state <= S_RD_CHK;
          end
        end
        S_RD_OLD2: begin
          old_r <= seq_tag;
          state <= S_RD_CHK;
        end
        S_RD_CHK: begin
          if (!out_range) begin
            state <= S_RD_IDX;
          end else if (out_free) begin
            out_elem   <= '0;
            out_seq    <= '0;
            out_slot   <= '0;
            out_status <= shr_pkg::STATUS_RANGE;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_RD_IDX: begin
          if (!mod_rsp.busy) begin
            idx_r <= mod_rsp.rem;
            state <= S_RD_ELEM;
          end
        end
        S_RD_ELEM: begin
          if (out_free) begin
            out_elem   <= shr_pkg::WORD_W'(elem_rd_data);
            out_seq    <= '0;
            out_slot   <= idx_r;
            out_status <= shr_pkg::STATUS_OK;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_BACK1: begin
          if (!mod_rsp.busy) begin
            state <= S_SLOT;
          end
        end
        S_SLOT: begin
          if (!mod_rsp.busy && out_free) begin
            out_elem   <= '0;
            out_seq    <= '0;
            out_slot   <= mod_rsp.rem;
            out_status <= shr_pkg::STATUS_OK;
            out_last   <= 1'b1;
            state      <= S_IDLE;
          end
        end
        S_REC_DATA: begin
          if (out_free) begin
            out_elem   <= shr_pkg::WORD_W'(elem_rd_data);
            out_seq    <= '0;
            out_slot   <= idx_r;
            out_status <= shr_pkg::STATUS_OK;
            out_last   <= rec_fin;
            idx_r      <= nidx;
            cnt_r      <= cnt_r + 1'b1;
            if (rec_fin) begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // element store
  shr_ram #(
    .WIDTH (shr_pkg::ELEM_BITS),
    .DEPTH (shr_pkg::DEPTH)
  ) u_elem_ram (
    .clk     (clk),
    .wr_en   (elem_wr_en),
    .wr_addr (nxt),
    .wr_data (elem_r),
    .rd_en   (elem_rd_en),
    .rd_addr (elem_rd_addr),
    .rd_data (elem_rd_data)
  );

  // sequence tag store
  shr_ram #(
    .WIDTH (shr_pkg::SEQ_W),
    .DEPTH (shr_pkg::DEPTH)
  ) u_seq_ram (
    .clk     (clk),
    .wr_en   (seq_wr_en),
    .wr_addr (nxt),
    .wr_data (next_seq),
    .rd_en   (seq_rd_en),
    .rd_addr (seq_rd_addr),
    .rd_data (seq_rd_data)
  );

  // shared remainder unit
  shr_mod u_mod (
    .clk (clk),
    .rst (rst),
    .len (eff_len),
    .req (mod_req),
    .rsp (mod_rsp)
  );

  // output word packing
  always_comb begin
    m_axis_tvalid   = out_valid;
    m_axis_tdata    = {2'b00, out_slot, out_seq, out_elem};
    m_axis_tuser[0] = out_status;
    m_axis_tlast    = out_last;
  end

`ifndef SYNTHESIS
  // an append never leaves head and tail on the same slot
  a_head_tail_apart: assert property (@(posedge clk) disable iff (rst)
    app_fire |=> head_slot != tail_slot)
    else $error("append left head on tail");

  // an appended head stays inside the ring
  a_head_in_ring: assert property (@(posedge clk) disable iff (rst)
    app_fire && !cfg_wr_en |=> head_slot < SW'(eff_len - 1'b1) ||
                              head_slot == SW'(eff_len - 1'b1))
    else $error("head outside ring after append");

  // a new command word is never taken in the middle of a recall run
  a_no_take_mid_run: assert property (@(posedge clk) disable iff (rst)
    in_fire |-> !(out_valid && !out_last))
    else $error("command taken while a recall run is open");
`endif

endmodule

`default_nettype wire

// ----- design/shr_ram.sv -----
// generic single-write, single-read ram with registered read data
`default_nettype none

module shr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- design/shr_mod.sv -----
// bit-serial remainder unit: value modulo ring length, one dividend bit per cycle
`default_nettype none

module shr_mod (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic [shr_pkg::LEN_W-1:0] len,
  input  wire shr_pkg::mod_req_t        req,
  output shr_pkg::mod_rsp_t             rsp
);

  logic [shr_pkg::MOD_W-1:0]  shreg;
  logic [shr_pkg::CNT_W-1:0]  cnt;
  logic [shr_pkg::SLOT_W-1:0] rem;
  logic [shr_pkg::SLOT_W:0]   r2;
  logic [shr_pkg::SLOT_W:0]   len_ext;

  // one restoring step: shift in the next bit, subtract the length once
  always_comb begin
    r2      = {rem, shreg[shr_pkg::MOD_W-1]};
    len_ext = (shr_pkg::SLOT_W + 1)'(len);
  end

  // step counter, dividend shifter and partial remainder
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      rem <= '0;
      if (req.wide) begin
        shreg <= req.value;
        cnt   <= shr_pkg::CNT_W'(shr_pkg::MOD_W);
      end else begin
        shreg <= {req.value[shr_pkg::NARROW_W-1:0],
                  (shr_pkg::MOD_W - shr_pkg::NARROW_W)'(0)};
        cnt   <= shr_pkg::CNT_W'(shr_pkg::NARROW_W);
      end
    end else if (cnt != '0) begin
      if (r2 >= len_ext) begin
        rem <= shr_pkg::SLOT_W'(r2 - len_ext);
      end else begin
        rem <= shr_pkg::SLOT_W'(r2);
      end
      shreg <= shreg << 1;
      cnt   <= cnt - 1'b1;
    end
  end

  always_comb begin
    rsp.busy = (cnt != '0);
    rsp.rem  = rem;
  end

`ifndef SYNTHESIS
  // the sequencer never restarts the unit in the middle of a division
  a_no_restart: assert property (@(posedge clk) disable iff (rst)
    req.start |-> !rsp.busy)
    else $error("remainder unit restarted while busy");
`endif

endmodule

`default_nettype wire
